>>> design/sbf_pkg.sv
`default_nettype none

package sbf_pkg;

    // Field widths fixed by the stream and register formats.
    localparam int HASH_W          = 64;
    localparam int NUM_HASH_FIELDS = 8;
    localparam int IN_TDATA_W      = HASH_W * NUM_HASH_FIELDS;
    localparam int OUT_TDATA_W     = 8;
    localparam int ACTIVE_W        = 3;

    localparam int CFG_INDEX_W     = 2;
    localparam int CFG_DATA_W      = 16;
    localparam int STACK_BITS_W    = 15;
    localparam int HASHES_USED_W   = 4;
    localparam int INSERTS_W       = 16;
    localparam int LIMIT_W         = 3;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_W-1:0] CFG_STACK_BITS  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HASHES_USED = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_INSERTS     = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_STACK_LIMIT = 2'd3;

    // Register reset values.
    localparam logic [STACK_BITS_W-1:0]  STACK_BITS_RST  = 15'd16384;
    localparam logic [HASHES_USED_W-1:0] HASHES_USED_RST = 4'd4;
    localparam logic [INSERTS_W-1:0]     INSERTS_RST     = 16'd1000;
    localparam logic [LIMIT_W-1:0]       STACK_LIMIT_RST = 3'd0;

    localparam int MIN_STACK_BITS = 8;
    localparam logic [INSERTS_W-1:0] COUNT_MAX = 16'hFFFF;

    typedef enum logic [3:0] {
        ST_CLEAR_ALL,
        ST_IDLE,
        ST_MOD_START,
        ST_MOD_WAIT,
        ST_CHK_RD,
        ST_CHK_EVAL,
        ST_INS,
        ST_UPDATE,
        ST_GROW_CLR,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

>>> design/sbf_mod_unit.sv
`default_nettype none

// Restoring remainder unit: one dividend bit per cycle, most significant first.
module sbf_mod_unit #(
    parameter int DIV_W = 15
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [sbf_pkg::HASH_W-1:0] dividend,
    input  wire logic [DIV_W-1:0]           divisor,
    output logic                            done,
    output logic [DIV_W-1:0]                remainder
);
    import sbf_pkg::*;

    localparam int CNT_W = $clog2(HASH_W + 1);

    logic [HASH_W-1:0] shift_reg, shift_next;
    logic [DIV_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [DIV_W:0]    trial;
    logic [DIV_W:0]    reduced;

    // The partial remainder stays below the divisor, so one subtract per step.
    assign trial   = {rem_reg, shift_reg[HASH_W-1]};
    assign reduced = (trial >= {1'b0, divisor}) ? (trial - {1'b0, divisor}) : trial;

    always_comb
    begin
        shift_next = shift_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        if (start)
        begin
            shift_next = dividend;
            rem_next   = '0;
            cnt_next   = CNT_W'(HASH_W);
        end
        else if (cnt_reg != '0)
        begin
            shift_next = {shift_reg[HASH_W-2:0], 1'b0};
            rem_next   = reduced[DIV_W-1:0];
            cnt_next   = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

>>> design/sbf_bit_mem.sv
`default_nettype none

// Single-port bit store with a registered read.
module sbf_bit_mem #(
    parameter int DEPTH  = 65536,
    parameter int ADDR_W = 16
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic              wdata,
    output logic                   rdata
);

    logic mem [DEPTH];
    logic rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> design/stacked_bloom_filter_core.sv
`default_nettype none

// Work per item: the shared remainder unit reduces each of the H hashes in turn, each bit
// probed across the active stacks takes a read and a check, then H insert writes on a miss,
// plus a sweep of the new stack when one opens. One item at a time; the remainder unit and
// the single memory port serve one step at a time. After reset the bit store is swept to
// zero, one bit a cycle, before the first item is taken.
module stacked_bloom_filter_core #(
    parameter int MAX_STACK_BITS = 16384,
    parameter int MAX_STACKS     = 4,
    parameter int MAX_HASHES     = 8
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // hash_0, hash_1, ..., hash_7, 64 bits each
    input  wire logic [sbf_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // found, active_stacks[2:0], rebuild_needed, capacity_full, two zero bits
    output logic [sbf_pkg::OUT_TDATA_W-1:0]      m_tdata,
    input  wire logic                            cfg_we,
    input  wire logic [sbf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [sbf_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import sbf_pkg::*;

    localparam int STORE_BITS = MAX_STACKS * MAX_STACK_BITS;
    localparam int AW         = $clog2(STORE_BITS);
    localparam int NBW        = $clog2(MAX_STACK_BITS + 1);
    localparam int PW         = $clog2(MAX_STACK_BITS);
    localparam int SCW        = $clog2(MAX_STACKS + 1);
    localparam int HIW        = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1;

    state_t state_reg, state_next;

    logic [STACK_BITS_W-1:0]  stack_bits_reg;
    logic [HASHES_USED_W-1:0] hashes_used_reg;
    logic [INSERTS_W-1:0]     inserts_reg;
    logic [LIMIT_W-1:0]       limit_reg;

    logic [HASH_W-1:0] hash_reg [MAX_HASHES];
    logic [PW-1:0]     pos_reg  [MAX_HASHES];
    logic              hash_load;
    logic              pos_load;

    logic [NBW-1:0]       nb_reg, nb_next;
    logic [HIW-1:0]       nh_last_reg, nh_last_next;
    logic [HIW-1:0]       idx_reg, idx_next;
    logic [SCW-1:0]       stack_idx_reg, stack_idx_next;
    logic [AW-1:0]        base_reg, base_next;
    logic                 found_reg, found_next;
    logic [SCW-1:0]       sc_reg, sc_next;
    logic [INSERTS_W-1:0] ic_reg, ic_next;
    logic                 rebuild_reg, rebuild_next;
    logic                 full_reg, full_next;
    logic [AW-1:0]        clr_addr_reg, clr_addr_next;
    logic [NBW-1:0]       clr_cnt_reg, clr_cnt_next;

    logic                m_valid_reg, m_valid_next;
    logic                out_found_reg, out_found_next;
    logic [ACTIVE_W-1:0] out_active_reg, out_active_next;
    logic                out_rebuild_reg, out_rebuild_next;
    logic                out_full_reg, out_full_next;

    logic [NBW-1:0]       eff_bits;
    logic [HIW-1:0]       eff_nh_last;
    logic [PW-1:0]        cur_pos;
    logic [AW-1:0]        bit_addr;
    logic                 idx_last;
    logic                 stack_last;
    logic [INSERTS_W-1:0] ic_inc;
    logic                 due;
    logic                 grow;
    logic [SCW-1:0]       sc_after;
    logic                 out_free;

    logic                 mod_start;
    logic                 mod_done;
    logic [NBW-1:0]       mod_rem;
    logic                 mem_we;
    logic [AW-1:0]        mem_addr;
    logic                 mem_wdata;
    logic                 mem_rdata;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stack_bits_reg  <= STACK_BITS_RST;
            hashes_used_reg <= HASHES_USED_RST;
            inserts_reg     <= INSERTS_RST;
            limit_reg       <= STACK_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_STACK_BITS:  stack_bits_reg  <= cfg_data[STACK_BITS_W-1:0];
                CFG_HASHES_USED: hashes_used_reg <= cfg_data[HASHES_USED_W-1:0];
                CFG_INSERTS:     inserts_reg     <= cfg_data[INSERTS_W-1:0];
                CFG_STACK_LIMIT: limit_reg       <= cfg_data[LIMIT_W-1:0];
                default:         ;
            endcase
        end
    end

    // Effective modulus and hash count, clamped to the built range.
    always_comb
    begin
        if (32'(stack_bits_reg) < 32'(MIN_STACK_BITS))
        begin
            eff_bits = NBW'(MIN_STACK_BITS);
        end
        else if (32'(stack_bits_reg) > 32'(MAX_STACK_BITS))
        begin
            eff_bits = NBW'(MAX_STACK_BITS);
        end
        else
        begin
            eff_bits = NBW'(stack_bits_reg);
        end

        if (hashes_used_reg == '0)
        begin
            eff_nh_last = '0;
        end
        else if (32'(hashes_used_reg) > 32'(MAX_HASHES))
        begin
            eff_nh_last = HIW'(MAX_HASHES - 1);
        end
        else
        begin
            eff_nh_last = HIW'(hashes_used_reg - 1'b1);
        end
    end

    assign cur_pos    = pos_reg[idx_reg];
    assign bit_addr   = AW'(32'(base_reg) + 32'(cur_pos));
    assign idx_last   = (idx_reg == nh_last_reg);
    assign stack_last = (SCW'(stack_idx_reg + 1'b1) == sc_reg);
    assign out_free   = !m_valid_reg || m_tready;

    // Insert bookkeeping: count, growth and the latched flags.
    assign ic_inc   = (ic_reg == COUNT_MAX) ? ic_reg : ic_reg + 1'b1;
    assign due      = (ic_inc >= inserts_reg) &&
                      ((limit_reg == '0) || (32'(sc_reg) < 32'(limit_reg)));
    assign grow     = due && (32'(sc_reg) < 32'(MAX_STACKS));
    assign sc_after = grow ? SCW'(sc_reg + 1'b1) : sc_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR_ALL:
            begin
                if (clr_addr_reg == AW'(STORE_BITS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_MOD_START;
                end
            end
            ST_MOD_START:
            begin
                state_next = ST_MOD_WAIT;
            end
            ST_MOD_WAIT:
            begin
                if (mod_done)
                begin
                    state_next = idx_last ? ST_CHK_RD : ST_MOD_START;
                end
            end
            ST_CHK_RD:
            begin
                state_next = ST_CHK_EVAL;
            end
            ST_CHK_EVAL:
            begin
                if (mem_rdata)
                begin
                    state_next = idx_last ? ST_OUT : ST_CHK_RD;
                end
                else
                begin
                    state_next = stack_last ? ST_INS : ST_CHK_RD;
                end
            end
            ST_INS:
            begin
                if (idx_last)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = grow ? ST_GROW_CLR : ST_OUT;
            end
            ST_GROW_CLR:
            begin
                if (clr_cnt_reg == '0)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs.
    always_comb
    begin
        nb_next          = nb_reg;
        nh_last_next     = nh_last_reg;
        idx_next         = idx_reg;
        stack_idx_next   = stack_idx_reg;
        base_next        = base_reg;
        found_next       = found_reg;
        sc_next          = sc_reg;
        ic_next          = ic_reg;
        rebuild_next     = rebuild_reg;
        full_next        = full_reg;
        clr_addr_next    = clr_addr_reg;
        clr_cnt_next     = clr_cnt_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        out_found_next   = out_found_reg;
        out_active_next  = out_active_reg;
        out_rebuild_next = out_rebuild_reg;
        out_full_next    = out_full_reg;
        hash_load        = 1'b0;
        pos_load         = 1'b0;
        mod_start        = 1'b0;
        mem_we           = 1'b0;
        mem_addr         = bit_addr;
        mem_wdata        = 1'b0;

        case (state_reg)
            ST_CLEAR_ALL:
            begin
                mem_we        = 1'b1;
                mem_addr      = clr_addr_reg;
                clr_addr_next = AW'(clr_addr_reg + 1'b1);
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    hash_load    = 1'b1;
                    nb_next      = eff_bits;
                    nh_last_next = eff_nh_last;
                    idx_next     = '0;
                end
            end
            ST_MOD_START:
            begin
                mod_start = 1'b1;
            end
            ST_MOD_WAIT:
            begin
                if (mod_done)
                begin
                    pos_load = 1'b1;
                    if (idx_last)
                    begin
                        idx_next       = '0;
                        stack_idx_next = '0;
                        base_next      = '0;
                        found_next     = 1'b0;
                    end
                    else
                    begin
                        idx_next = HIW'(idx_reg + 1'b1);
                    end
                end
            end
            ST_CHK_EVAL:
            begin
                if (mem_rdata)
                begin
                    if (idx_last)
                    begin
                        found_next = 1'b1;
                    end
                    else
                    begin
                        idx_next = HIW'(idx_reg + 1'b1);
                    end
                end
                else
                begin
                    // A clear bit rules out this stack. After the last stack the
                    // base stays on it, which is where the insert goes.
                    idx_next = '0;
                    if (!stack_last)
                    begin
                        stack_idx_next = SCW'(stack_idx_reg + 1'b1);
                        base_next      = AW'(32'(base_reg) + 32'(nb_reg));
                    end
                end
            end
            ST_INS:
            begin
                mem_we    = 1'b1;
                mem_wdata = 1'b1;
                idx_next  = HIW'(idx_reg + 1'b1);
            end
            ST_UPDATE:
            begin
                sc_next = sc_after;
                if (grow)
                begin
                    ic_next       = '0;
                    clr_addr_next = AW'(32'(base_reg) + 32'(nb_reg));
                    clr_cnt_next  = NBW'(nb_reg - 1'b1);
                end
                else
                begin
                    ic_next = ic_inc;
                    if (due)
                    begin
                        full_next = 1'b1;
                    end
                end
                if ((limit_reg != '0) && (32'(sc_after) >= 32'(limit_reg)))
                begin
                    rebuild_next = 1'b1;
                end
            end
            ST_GROW_CLR:
            begin
                mem_we        = 1'b1;
                mem_addr      = clr_addr_reg;
                clr_addr_next = AW'(clr_addr_reg + 1'b1);
                clr_cnt_next  = NBW'(clr_cnt_reg - 1'b1);
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    m_valid_next     = 1'b1;
                    out_found_next   = found_reg;
                    out_active_next  = ACTIVE_W'(sc_reg);
                    out_rebuild_next = rebuild_reg;
                    out_full_next    = full_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR_ALL;
            sc_reg        <= SCW'(1);
            ic_reg        <= '0;
            rebuild_reg   <= 1'b0;
            full_reg      <= 1'b0;
            clr_addr_reg  <= '0;
            clr_cnt_reg   <= '0;
            idx_reg       <= '0;
            stack_idx_reg <= '0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sc_reg        <= sc_next;
            ic_reg        <= ic_next;
            rebuild_reg   <= rebuild_next;
            full_reg      <= full_next;
            clr_addr_reg  <= clr_addr_next;
            clr_cnt_reg   <= clr_cnt_next;
            idx_reg       <= idx_next;
            stack_idx_reg <= stack_idx_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nb_reg          <= nb_next;
        nh_last_reg     <= nh_last_next;
        base_reg        <= base_next;
        found_reg       <= found_next;
        out_found_reg   <= out_found_next;
        out_active_reg  <= out_active_next;
        out_rebuild_reg <= out_rebuild_next;
        out_full_reg    <= out_full_next;
        if (pos_load)
        begin
            pos_reg[idx_reg] <= PW'(mod_rem);
        end
    end

    always_ff @(posedge clk)
    begin
        if (hash_load)
        begin
            for (int i = 0; i < MAX_HASHES; i++)
            begin
                hash_reg[i] <= s_tdata[i*HASH_W +: HASH_W];
            end
        end
    end

    sbf_mod_unit #(
        .DIV_W (NBW)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (hash_reg[idx_reg]),
        .divisor   (nb_reg),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    sbf_bit_mem #(
        .DEPTH  (STORE_BITS),
        .ADDR_W (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, out_full_reg, out_rebuild_reg, out_active_reg, out_found_reg};

endmodule

`default_nettype wire

>>> test/bloom_checker.sv
module bloom_checker #(
    parameter int MAX_STACK_BITS = 16384,
    parameter int MAX_STACKS     = 4,
    parameter int MAX_HASHES     = 8
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    input  wire logic                            s_tready,
    input  wire logic [sbf_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  wire logic                            m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic [sbf_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  wire logic                            cfg_we,
    input  wire logic [sbf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [sbf_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                                   outstanding,
    output int                                   mismatch_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import sbf_pkg::*;

    localparam int STORE_BITS = MAX_STACK_BITS * MAX_STACKS;

    typedef struct packed {
        logic                found;
        logic [ACTIVE_W-1:0] active;
        logic                rebuild;
        logic                full;
    } outcome_t;

    // Shadow of the filter: one flat bit array holding every stack back to back.
    logic        bloom_mem [0:STORE_BITS-1];
    int unsigned stacks_open;
    int unsigned adds_since_open;
    logic        rebuild_latched;
    logic        full_latched;

    logic [STACK_BITS_W-1:0]  cfg_width;
    logic [HASHES_USED_W-1:0] cfg_hash_cnt;
    logic [INSERTS_W-1:0]     cfg_per_stack;
    logic [LIMIT_W-1:0]       cfg_stack_cap;

    outcome_t queued_outcomes[$];

    // Looks the element up in every open stack; if it is absent it is added to
    // the newest stack, which may open a further stack or latch the flags.
    function automatic outcome_t probe_and_insert(input logic [IN_TDATA_W-1:0] elem);
        int unsigned width;
        int unsigned nhash;
        int unsigned slot [MAX_HASHES];
        int unsigned base;
        logic        hit;
        logic        all_set;
        logic [HASH_W-1:0] h;
        outcome_t    res;

        width = cfg_width;
        if (width < MIN_STACK_BITS)
            width = MIN_STACK_BITS;
        if (width > MAX_STACK_BITS)
            width = MAX_STACK_BITS;
        nhash = cfg_hash_cnt;
        if (nhash < 1)
            nhash = 1;
        if (nhash > MAX_HASHES)
            nhash = MAX_HASHES;

        for (int i = 0; i < nhash; i++)
        begin
            h = elem[i*HASH_W +: HASH_W];
            slot[i] = int'(h % 64'(width));
        end

        hit = 1'b0;
        for (int s = 0; s < stacks_open && !hit; s++)
        begin
            all_set = 1'b1;
            for (int i = 0; i < nhash; i++)
                if (!bloom_mem[s * width + slot[i]])
                    all_set = 1'b0;
            hit = all_set;
        end

        if (!hit)
        begin
            base = (stacks_open - 1) * width;
            for (int i = 0; i < nhash; i++)
                bloom_mem[base + slot[i]] = 1'b1;
            if (adds_since_open < COUNT_MAX)
                adds_since_open++;
            if (adds_since_open >= cfg_per_stack &&
                (cfg_stack_cap == 0 || stacks_open < cfg_stack_cap))
            begin
                if (stacks_open < MAX_STACKS)
                begin
                    base = stacks_open * width;
                    for (int k = 0; k < width; k++)
                        bloom_mem[base + k] = 1'b0;
                    stacks_open++;
                    adds_since_open = 0;
                end
                else
                begin
                    full_latched = 1'b1;
                end
            end
            if (cfg_stack_cap != 0 && stacks_open >= cfg_stack_cap)
                rebuild_latched = 1'b1;
        end

        res.found   = hit;
        res.active  = stacks_open[ACTIVE_W-1:0];
        res.rebuild = rebuild_latched;
        res.full    = full_latched;
        return res;
    endfunction

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        outcome_t got;
        if (!rst_n)
        begin
            for (int k = 0; k < STORE_BITS; k++)
                bloom_mem[k] = 1'b0;
            stacks_open     = 1;
            adds_since_open = 0;
            rebuild_latched = 1'b0;
            full_latched    = 1'b0;
            cfg_width       = STACK_BITS_RST;
            cfg_hash_cnt    = HASHES_USED_RST;
            cfg_per_stack   = INSERTS_RST;
            cfg_stack_cap   = STACK_LIMIT_RST;
            queued_outcomes.delete();
            mismatch_count  = 0;
            outstanding    <= 0;
        end
        else
        begin
            // The result leaving at this edge belongs to an older transaction, so it
            // is matched before the one accepted at the same edge is queued.
            if (m_tvalid && m_tready)
            begin
                got = '{found: m_tdata[0], active: m_tdata[3:1],
                        rebuild: m_tdata[4], full: m_tdata[5]};
                if (queued_outcomes.size() == 0)
                begin
                    $display("%0t: result with nothing outstanding, expected none, actual %h",
                             $time, m_tdata);
                    mismatch_count++;
                end
                else
                begin
                    want = queued_outcomes.pop_front();
                    compare_field("found", int'(want.found), int'(got.found));
                    compare_field("active_stacks", int'(want.active), int'(got.active));
                    compare_field("rebuild_needed", int'(want.rebuild), int'(got.rebuild));
                    compare_field("capacity_full", int'(want.full), int'(got.full));
                end
            end
            if (s_tvalid && s_tready)
                queued_outcomes.push_back(probe_and_insert(s_tdata));
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_STACK_BITS:  cfg_width     = cfg_data[STACK_BITS_W-1:0];
                    CFG_HASHES_USED: cfg_hash_cnt  = cfg_data[HASHES_USED_W-1:0];
                    CFG_INSERTS:     cfg_per_stack = cfg_data[INSERTS_W-1:0];
                    CFG_STACK_LIMIT: cfg_stack_cap = cfg_data[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            outstanding <= queued_outcomes.size();
        end
    end

endmodule

>>> test/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sbf_pkg::*;

    localparam int MAX_STACK_BITS = 16384;
    localparam int MAX_STACKS     = 4;
    localparam int MAX_HASHES     = 8;
    localparam logic [HASH_W-1:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    int outstanding;
    int mismatch_count;

    int source_idle_pct = 6;
    int sink_idle_pct   = 50;

    // Elements sent lately; replaying them is what makes lookups hit.
    logic [IN_TDATA_W-1:0] recent_elements[$];

    stacked_bloom_filter_core #(
        .MAX_STACK_BITS (MAX_STACK_BITS),
        .MAX_STACKS     (MAX_STACKS),
        .MAX_HASHES     (MAX_HASHES)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bloom_checker #(
        .MAX_STACK_BITS (MAX_STACK_BITS),
        .MAX_STACKS     (MAX_STACKS),
        .MAX_HASHES     (MAX_HASHES)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .outstanding    (outstanding),
        .mismatch_count (mismatch_count)
    );

    always #5 clk = ~clk;

    initial
    begin
        #(50_000_000);
        $display("FAIL");
        $finish;
    end

    // Result side: random back-pressure, plus one long hold-off after the 30th
    // result so that the core stalls with a transaction waiting at its input.
    int  results_taken;
    int  hold_left;
    logic hold_done;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready      <= 1'b0;
            results_taken <= 0;
            hold_left     <= 0;
            hold_done     <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                results_taken <= results_taken + 1;
            if (hold_left != 0)
            begin
                m_tready  <= 1'b0;
                hold_left <= hold_left - 1;
            end
            else if (!hold_done && results_taken == 30)
            begin
                m_tready  <= 1'b0;
                hold_left <= 3000;
                hold_done <= 1'b1;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    function automatic logic [HASH_W-1:0] random_hash();
        case ($urandom_range(15))
            0:       return '0;
            1:       return ONES;
            2:       return 64'($urandom_range(40));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // The ready line only moves at rising edges, so its value at the falling
    // edge tells whether the transaction is taken at the next rising edge.
    task automatic send_element(input logic [IN_TDATA_W-1:0] elem);
        while ($urandom_range(99) < source_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= elem;
        @(negedge clk);
        while (!s_tready)
            @(negedge clk);
        @(posedge clk);
        recent_elements.push_back(elem);
        if (recent_elements.size() > 64)
            recent_elements.delete(0);
    endtask

    // Mostly fresh elements, with replays and near-replays of recent ones.
    task automatic send_random(input int count);
        logic [IN_TDATA_W-1:0] elem;
        int roll;
        int pick;
        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(99);
            if (recent_elements.size() != 0 && roll < 35)
            begin
                pick = $urandom_range(recent_elements.size() - 1);
                elem = recent_elements[pick];
                if (roll >= 25)
                begin
                    pick = $urandom_range(MAX_HASHES - 1);
                    elem[pick*HASH_W +: HASH_W] = random_hash();
                end
            end
            else
            begin
                for (int i = 0; i < MAX_HASHES; i++)
                    elem[i*HASH_W +: HASH_W] = random_hash();
            end
            send_element(elem);
        end
    endtask

    // Waits until every transaction has its result and the core is back at rest.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] width,
                             input logic [CFG_DATA_W-1:0] hashes,
                             input logic [CFG_DATA_W-1:0] per_stack,
                             input logic [CFG_DATA_W-1:0] limit);
        write_reg(CFG_STACK_BITS, width);
        write_reg(CFG_HASHES_USED, hashes);
        write_reg(CFG_INSERTS, per_stack);
        write_reg(CFG_STACK_LIMIT, limit);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Power-on settings: an empty store, then a repeat and a match that
        // differs only in hashes beyond the used count.
        send_element('0);
        send_element('0);
        send_element({MAX_HASHES{ONES}});
        send_element({{4{64'h0}}, {4{ONES}}});
        send_element({MAX_HASHES{64'hAAAA_AAAA_AAAA_AAAA}});
        send_element({MAX_HASHES{64'h5555_5555_5555_5555}});
        drain();

        // Growth to a limit of two, which latches the rebuild flag.
        configure(16'd256, 16'd3, 16'd20, 16'd2);
        send_random(80);
        drain();

        // Every register written with all ones: width and hash count clamp,
        // and a limit above the built capacity.
        configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_element({MAX_HASHES{ONES}});
        send_element({MAX_HASHES{ONES}});
        send_random(60);
        drain();

        source_idle_pct = 50;
        sink_idle_pct   = 6;

        // Width below the minimum and a zero hash count: a tiny store that fills.
        configure(16'd3, 16'd0, 16'd1, 16'd1);
        send_element({{7{ONES}}, 64'd0});
        send_element({{7{ONES}}, 64'd8});
        send_element({{7{ONES}}, 64'd7});
        send_element({{7{64'd0}}, ONES});
        send_random(40);
        drain();

        // A new stack after every insert until capacity runs out.
        configure(16'd64, 16'd2, 16'd0, 16'd0);
        send_random(80);
        drain();

        source_idle_pct = 0;
        sink_idle_pct   = 0;

        configure(16'd16384, 16'd8, 16'd1000, 16'd4);
        send_random(80);
        drain();

        configure(16'd1000, 16'd5, 16'd3, 16'd5);
        send_random(120);
        drain();

        repeat (50) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> stacked_bloom_filter_core.f
design/sbf_pkg.sv
design/sbf_mod_unit.sv
design/sbf_bit_mem.sv
design/stacked_bloom_filter_core.sv
test/bloom_checker.sv
test/tb.sv
